// ----- sv/sass_pkg.sv -----
// Package: types and constants for the sprite animation sequencer.
`default_nettype none
package sass_pkg;
   localparam int SCRIPT_DEPTH = 256;
   localparam int PATH_DEPTH   = 256;
   localparam int MAX_FRAMES   = 64;
   localparam int FETCH_LIMIT  = SCRIPT_DEPTH + 1;
   localparam int FETCH_W      = $clog2(FETCH_LIMIT + 1);

   typedef enum logic [2:0] {
      KIND_TICK   = 3'd0,
      KIND_WR_SCR = 3'd1,
      KIND_WR_PTH = 3'd2,
      KIND_ST_SCR = 3'd3,
      KIND_ST_PTH = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      CMD_SPEED    = 3'd0,
      CMD_GO       = 3'd1,
      CMD_FORWARD  = 3'd2,
      CMD_BACKWARD = 3'd3,
      CMD_WAIT     = 3'd4,
      CMD_END      = 3'd5,
      CMD_START    = 3'd6,
      CMD_START_B  = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_TOTAL_FRAMES = 2'd0,
      CSR_FRAME_LOOP   = 2'd1,
      CSR_PATH_PERIOD  = 2'd2
   } csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PATH_RD,
      ST_PATH_MV,
      ST_GATE,
      ST_WALK,
      ST_FETCH,
      ST_DONE
   } state_type;
endpackage
`default_nettype wire

// ----- sv/sprite_animation_script_sequencer_core.sv -----
// Top level: sprite animation script and path sequencer.
//
//  channel | ports                                  | handshake
//  req     | req_kind .. req_path_steps             | start & !busy
//  rsp     | rsp_frame .. rsp_script_running        | rsp_valid, one cycle
//  csr     | csr_index, csr_wdata                   | csr_valid & csr_ready
//
// Table writes and starts go from idle straight to done. A tick passes path
// read, path move and the speed gate and ends there when the script is off
// or gated; else it adds a walker visit per command step and a script fetch
// (memory data state) per load, at most SCRIPT_DEPTH+1 fetches. The walker is
// the shared unit. The result beat comes in the same cycle that busy drops.
// Reset is synchronous; memories are not cleared. Results cannot be stalled.
`default_nettype none
module sprite_animation_script_sequencer_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_kind,
   input  wire logic [7:0]  req_index,
   input  wire logic [2:0]  req_opcode,
   input  wire logic [15:0] req_value,
   input  wire logic signed [15:0] req_point_x,
   input  wire logic signed [15:0] req_point_y,
   input  wire logic [8:0]  req_path_steps,
   output logic             rsp_valid,
   output logic [5:0]       rsp_frame,
   output logic signed [15:0] rsp_loc_x,
   output logic signed [15:0] rsp_loc_y,
   output logic             rsp_frame_changed,
   output logic             rsp_moved,
   output logic             rsp_script_running,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   import sass_pkg::*;

   // memories
   logic [18:0] script_mem [SCRIPT_DEPTH];
   logic [31:0] path_mem [PATH_DEPTH];
   logic [18:0] scr_rd_ff;
   logic [31:0] pth_rd_ff;

   state_type state_ff, state_in;

   // configuration
   logic [6:0]  total_frames_ff;
   logic        frame_loop_ff;
   logic [15:0] path_period_ff;

   // item latch
   logic [2:0]  kind_ff;
   logic [7:0]  index_ff;
   logic [2:0]  opcode_ff;
   logic [15:0] value_ff;
   logic [15:0] px_ff, py_ff;
   logic [8:0]  steps_ff;

   // sequencer state
   logic [31:0] now_ff, now_in;
   logic [31:0] spd_dl_ff, spd_dl_in;
   logic [15:0] spd_per_ff, spd_per_in;
   logic [31:0] wait_dl_ff, wait_dl_in;
   logic        wait_arm_ff, wait_arm_in;
   logic        fwd_arm_ff, fwd_arm_in;
   logic        bwd_arm_ff, bwd_arm_in;
   logic [15:0] step_cnt_ff, step_cnt_in;
   logic [2:0]  cmd_ff, cmd_in;
   logic [15:0] opnd_ff, opnd_in;
   logic [7:0]  cursor_ff, cursor_in;
   logic        script_on_ff, script_on_in;
   logic [5:0]  frame_ff, frame_in;
   logic [5:0]  old_frame_ff, old_frame_in;
   logic        path_on_ff, path_on_in;
   logic [7:0]  path_idx_ff, path_idx_in;
   logic [8:0]  path_len_ff, path_len_in;
   logic [31:0] path_dl_ff, path_dl_in;
   logic [15:0] loc_x_ff, loc_x_in, loc_y_ff, loc_y_in;
   logic        moved_ff, moved_in;
   logic [FETCH_W-1:0] fetches_ff, fetches_in;

   logic [6:0]  nfr;
   logic        accept;
   logic        scr_we, pth_we;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // effective frame count
   always_comb begin
      nfr = total_frames_ff;
      if (nfr > 7'(MAX_FRAMES)) nfr = 7'(MAX_FRAMES);
      if (nfr > 7'd64) nfr = 7'd64;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         total_frames_ff <= '0;
         frame_loop_ff   <= 1'b0;
         path_period_ff  <= 16'd5;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TOTAL_FRAMES: total_frames_ff <= csr_wdata[6:0];
            CSR_FRAME_LOOP:   frame_loop_ff   <= csr_wdata[0];
            CSR_PATH_PERIOD:  path_period_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // item latch
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= req_kind;
         index_ff  <= req_index;
         opcode_ff <= req_opcode;
         value_ff  <= req_value;
         px_ff     <= req_point_x;
         py_ff     <= req_point_y;
         steps_ff  <= req_path_steps;
      end
   end

   // memory ports; the script read follows the next cursor so a rewind is seen
   assign scr_we = (state_ff == ST_DONE) && (kind_ff == KIND_WR_SCR);
   assign pth_we = (state_ff == ST_DONE) && (kind_ff == KIND_WR_PTH);
   always_ff @(posedge clock) begin
      if (scr_we)
         script_mem[index_ff] <= {(opcode_ff > CMD_END) ? CMD_END : opcode_ff, value_ff};
      scr_rd_ff <= script_mem[cursor_in];
   end
   always_ff @(posedge clock) begin
      if (pth_we) path_mem[index_ff] <= {px_ff, py_ff};
      pth_rd_ff <= path_mem[path_idx_ff];
   end

   // state register and sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         now_ff       <= '0;
         spd_dl_ff    <= '0;
         spd_per_ff   <= '0;
         wait_dl_ff   <= '0;
         wait_arm_ff  <= 1'b0;
         fwd_arm_ff   <= 1'b0;
         bwd_arm_ff   <= 1'b0;
         step_cnt_ff  <= '0;
         cmd_ff       <= CMD_START;
         opnd_ff      <= '0;
         cursor_ff    <= '0;
         script_on_ff <= 1'b0;
         frame_ff     <= '0;
         old_frame_ff <= '0;
         path_on_ff   <= 1'b0;
         path_idx_ff  <= '0;
         path_len_ff  <= '0;
         path_dl_ff   <= '0;
         loc_x_ff     <= '0;
         loc_y_ff     <= '0;
         moved_ff     <= 1'b0;
         fetches_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         spd_dl_ff    <= spd_dl_in;
         spd_per_ff   <= spd_per_in;
         wait_dl_ff   <= wait_dl_in;
         wait_arm_ff  <= wait_arm_in;
         fwd_arm_ff   <= fwd_arm_in;
         bwd_arm_ff   <= bwd_arm_in;
         step_cnt_ff  <= step_cnt_in;
         cmd_ff       <= cmd_in;
         opnd_ff      <= opnd_in;
         cursor_ff    <= cursor_in;
         script_on_ff <= script_on_in;
         frame_ff     <= frame_in;
         old_frame_ff <= old_frame_in;
         path_on_ff   <= path_on_in;
         path_idx_ff  <= path_idx_in;
         path_len_ff  <= path_len_in;
         path_dl_ff   <= path_dl_in;
         loc_x_ff     <= loc_x_in;
         loc_y_ff     <= loc_y_in;
         moved_ff     <= moved_in;
         fetches_ff   <= fetches_in;
      end
   end

   // sequencer: next state and walker step
   always_comb begin
      logic [15:0] sc;
      logic        fwd;
      state_in     = state_ff;
      now_in       = now_ff;
      spd_dl_in    = spd_dl_ff;
      spd_per_in   = spd_per_ff;
      wait_dl_in   = wait_dl_ff;
      wait_arm_in  = wait_arm_ff;
      fwd_arm_in   = fwd_arm_ff;
      bwd_arm_in   = bwd_arm_ff;
      step_cnt_in  = step_cnt_ff;
      cmd_in       = cmd_ff;
      opnd_in      = opnd_ff;
      cursor_in    = cursor_ff;
      script_on_in = script_on_ff;
      frame_in     = frame_ff;
      old_frame_in = old_frame_ff;
      path_on_in   = path_on_ff;
      path_idx_in  = path_idx_ff;
      path_len_in  = path_len_ff;
      path_dl_in   = path_dl_ff;
      loc_x_in     = loc_x_ff;
      loc_y_in     = loc_y_ff;
      moved_in     = moved_ff;
      fetches_in   = fetches_ff;
      sc           = step_cnt_ff;
      fwd          = (cmd_ff == CMD_FORWARD);
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               old_frame_in = frame_ff;
               moved_in     = 1'b0;
               case (req_kind)
                  KIND_TICK: begin
                     now_in   = now_ff + 32'd1;
                     state_in = ST_PATH_RD;
                  end
                  KIND_ST_SCR: begin
                     script_on_in = 1'b1;
                     cmd_in       = CMD_START;
                     fwd_arm_in   = 1'b0;
                     bwd_arm_in   = 1'b0;
                     wait_arm_in  = 1'b0;
                     state_in     = ST_DONE;
                  end
                  KIND_ST_PTH: begin
                     path_on_in  = 1'b1;
                     path_idx_in = req_index;
                     path_len_in = req_path_steps;
                     state_in    = ST_DONE;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         // path memory read in flight
         ST_PATH_RD: state_in = ST_PATH_MV;
         ST_PATH_MV: begin
            if (path_on_ff && (now_ff > path_dl_ff)) begin
               loc_x_in = pth_rd_ff[31:16];
               loc_y_in = pth_rd_ff[15:0];
               moved_in = 1'b1;
               if (path_len_ff <= 9'd1 || {1'b0, path_idx_ff} >= path_len_ff - 9'd1)
                  path_idx_in = '0;
               else
                  path_idx_in = path_idx_ff + 8'd1;
               path_dl_in = now_ff + 32'(path_period_ff);
            end
            state_in = ST_GATE;
         end
         // speed gate
         ST_GATE: begin
            fetches_in = '0;
            state_in   = ST_DONE;
            if (script_on_ff) begin
               if (cmd_ff == CMD_WAIT) state_in = ST_WALK;
               else if (!(now_ff < spd_dl_ff)) begin
                  spd_dl_in = now_ff + 32'(spd_per_ff);
                  state_in  = ST_WALK;
               end
            end
         end
         // one command per visit; a fetch goes through ST_FETCH
         ST_WALK: begin
            if (fetches_ff >= FETCH_W'(FETCH_LIMIT)) state_in = ST_DONE;
            else begin
               case (cmd_ff)
                  CMD_SPEED: begin
                     spd_per_in = opnd_ff;
                     spd_dl_in  = now_ff + 32'(opnd_ff);
                     state_in   = ST_FETCH;
                  end
                  CMD_GO: begin
                     if ({1'b0, opnd_ff} < 17'(nfr)) frame_in = opnd_ff[5:0];
                     state_in = ST_FETCH;
                  end
                  CMD_FORWARD, CMD_BACKWARD: begin
                     if (fwd && !fwd_arm_ff) begin
                        sc = opnd_ff; fwd_arm_in = 1'b1;
                     end
                     if (!fwd && !bwd_arm_ff) begin
                        sc = opnd_ff; bwd_arm_in = 1'b1;
                     end
                     if (nfr != 7'd0) begin
                        if (fwd) begin
                           if (7'(frame_ff) + 7'd1 < nfr) frame_in = frame_ff + 6'd1;
                           else if (frame_loop_ff) frame_in = '0;
                        end else begin
                           if (frame_ff != 6'd0) frame_in = frame_ff - 6'd1;
                           else if (frame_loop_ff) frame_in = 6'(nfr - 7'd1);
                        end
                     end
                     sc          = sc - 16'd1;
                     step_cnt_in = sc;
                     if (sc == 16'd0) begin
                        if (fwd) fwd_arm_in = 1'b0;
                        else bwd_arm_in = 1'b0;
                        state_in = ST_FETCH;
                     end else state_in = ST_DONE;
                  end
                  CMD_WAIT: begin
                     if (!wait_arm_ff) begin
                        wait_dl_in  = 32'(opnd_ff) + now_ff;
                        wait_arm_in = 1'b1;
                     end
                     state_in = ST_DONE;
                     if (now_ff > (wait_arm_ff ? wait_dl_ff : 32'(opnd_ff) + now_ff)) begin
                        wait_arm_in = 1'b0;
                        state_in    = ST_FETCH;
                     end
                  end
                  CMD_END: cmd_in = CMD_START;
                  default: begin
                     cursor_in   = '0;
                     fwd_arm_in  = 1'b0;
                     bwd_arm_in  = 1'b0;
                     wait_arm_in = 1'b0;
                     state_in    = ST_FETCH;
                  end
               endcase
            end
         end
         // memory data valid: load command, advance cursor
         ST_FETCH: begin
            cmd_in     = scr_rd_ff[18:16];
            opnd_in    = scr_rd_ff[15:0];
            cursor_in  = cursor_ff + 8'd1;
            fetches_in = fetches_ff + FETCH_W'(1);
            // go and wait stop after their fetch
            if (cmd_ff == CMD_GO || cmd_ff == CMD_WAIT) state_in = ST_DONE;
            else state_in = ST_WALK;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // result beat
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else rsp_valid <= (state_ff == ST_DONE);
   end
   always_ff @(posedge clock) begin
      rsp_frame          <= frame_ff;
      rsp_loc_x          <= loc_x_ff;
      rsp_loc_y          <= loc_y_ff;
      rsp_frame_changed  <= (frame_ff != old_frame_ff);
      rsp_moved          <= moved_ff;
      rsp_script_running <= script_on_ff;
   end

`ifndef SYNTH
   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("back-to-back result beats");
   a_busy_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while still busy");
   a_fetch_limit: assert property (@(posedge clock) disable iff (reset)
      fetches_ff <= FETCH_W'(FETCH_LIMIT)) else $error("walk ran past limit");
   a_moved_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_moved |-> rsp_script_running == script_on_ff)
      else $error("moved beat inconsistent");
`endif
endmodule
`default_nettype wire
